@@ rtl/core/kaseikyo_ir_frame_transmitter_assert.svh @@
// Assertion macros shared by the transmitter RTL.
`ifndef KASEIKYO_IR_FRAME_TRANSMITTER_ASSERT_SVH
`define KASEIKYO_IR_FRAME_TRANSMITTER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define KIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define KIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/kir_pkg.sv @@
package kir_pkg;

  localparam int FRAME_BITS = 48;
  localparam int TIMER_BITS = 20;
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);
  localparam int UNIT_W     = 12;
  localparam int GAP_W      = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [UNIT_W-1:0] UNIT_RESET  = UNIT_W'(432);
  localparam logic [GAP_W-1:0]  GAP_RESET   = GAP_W'(130000 - 56000);
  localparam logic [3:0]        NIBBLE_MASK = 4'hF;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_US       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP_US = CFG_IDX_W'(1);

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [BITS_W-1:0]     bits_t;

  localparam timer_t TIMER_MAX = '1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR_MARK,
    PH_HDR_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE,
    PH_STOP_MARK,
    PH_GAP
  } phase_t;

  typedef struct packed {
    logic        op;
    logic [11:0] address;
    logic [7:0]  command;
    logic [15:0] vendor_code;
    logic [7:0]  repeats;
  } req_t;

  typedef struct packed {
    logic ir_mark;
    logic busy_res;
    logic start_rejected;
  } res_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_us;
    logic [GAP_W-1:0]  repeat_gap_us;
  } cfg_t;

  function automatic timer_t timer_load(input logic [31:0] v);
    timer_t t;
    if (v > 32'(TIMER_MAX)) begin
      t = TIMER_MAX;
    end else begin
      t = v[TIMER_BITS-1:0];
    end
    return t;
  endfunction

endpackage

@@ rtl/core/kaseikyo_ir_frame_transmitter.sv @@
// Channel   Direction  Payload                      Handshake
// in_       input      op, address, command,        in_valid / in_ready
//                      vendor_code, repeats
// out_      output     ir_mark, busy_res,           out_valid / out_ready
//                      start_rejected
// cfg_      input      register index, write data   cfg_wr_en, no wait
//
// Every request yields exactly one result once the output is free. One request
// is accepted per cycle while the output is not stalled: the sequencer state is
// updated in the single cycle in which a request moves from the input register
// into the result register. Reset is synchronous and active low and returns the
// block to idle with the default timing unit and gap. A stalled output holds its
// result while one further request waits in the input register.
module kaseikyo_ir_frame_transmitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  kir_pkg::req_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output kir_pkg::res_t                       out_data,
  input  logic                                cfg_wr_en,
  input  logic [kir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kir_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import kir_pkg::*;
  `include "kaseikyo_ir_frame_transmitter_assert.svh"

  cfg_t cfg_r;
  logic s1_valid_r;
  req_t s1_data_r;
  logic out_valid_r;
  res_t out_data_r;
  logic s1_move;
  res_t seq_res;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_move;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_us       <= UNIT_RESET;
      cfg_r.repeat_gap_us <= GAP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_UNIT_US:       cfg_r.unit_us       <= cfg_wdata[UNIT_W-1:0];
        CFG_REPEAT_GAP_US: cfg_r.repeat_gap_us <= cfg_wdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_move) begin
      out_data_r <= seq_res;
    end
  end

  kir_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_go (s1_move),
    .item    (s1_data_r),
    .cfg     (cfg_r),
    .res     (seq_res)
  );

  `KIR_ASSERT(a_reject_when_busy, out_valid_r && out_data_r.start_rejected |-> out_data_r.busy_res, "rejected request without busy")
  `KIR_ASSERT(a_mark_when_busy, out_valid_r && out_data_r.ir_mark |-> out_data_r.busy_res, "mark outside a sequence")
  `KIR_ASSERT(a_tick_not_rejected, s1_move && s1_data_r.op == OP_TICK |=> !out_data_r.start_rejected, "tick flagged as rejected")
  `KIR_ASSERT_ALWAYS(a_ready_when_empty, !s1_valid_r |-> in_ready, "input stalled while empty")

endmodule

@@ rtl/core/kir_frame_build.sv @@
module kir_frame_build (
  input  kir_pkg::req_t   req,
  output kir_pkg::frame_t frame
);
  import kir_pkg::*;

  logic [3:0] vend_xor;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] parity;

  always_comb begin
    vend_xor = (req.vendor_code[3:0] ^ req.vendor_code[7:4] ^ req.vendor_code[11:8]
               ^ req.vendor_code[15:12]) & NIBBLE_MASK;
    byte2    = {req.address[3:0], vend_xor};
    byte3    = req.address[11:4];
    parity   = byte2 ^ byte3 ^ req.command;
    frame    = FRAME_BITS'({parity, req.command, byte3, byte2, req.vendor_code});
  end

endmodule

@@ rtl/core/kir_seq.sv @@
module kir_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_go,
  input  kir_pkg::req_t item,
  input  kir_pkg::cfg_t cfg,
  output kir_pkg::res_t res
);
  import kir_pkg::*;

  phase_t     phase_r, phase_nxt;
  timer_t     time_left_r, time_left_nxt;
  frame_t     frame_r, frame_nxt;
  bits_t      bits_left_r, bits_left_nxt;
  logic [7:0] frames_left_r, frames_left_nxt;

  frame_t            new_frame;
  logic [UNIT_W-1:0] unit_eff;
  timer_t            t_unit1, t_unit3, t_unit4, t_unit8, t_gap, t_dec;
  logic [7:0]        frame_cnt, frames_dec;
  bits_t             bits_dec;

  kir_frame_build u_frame_build (
    .req   (item),
    .frame (new_frame)
  );

  always_comb begin
    unit_eff   = (cfg.unit_us == '0) ? UNIT_W'(1) : cfg.unit_us;
    t_unit1    = timer_load(32'(unit_eff));
    t_unit3    = timer_load(32'(unit_eff) * 32'd3);
    t_unit4    = timer_load(32'(unit_eff) << 2);
    t_unit8    = timer_load(32'(unit_eff) << 3);
    t_gap      = timer_load(32'(cfg.repeat_gap_us));
    t_dec      = time_left_r - TIMER_BITS'(1);
    frame_cnt  = item.repeats + 8'd1;
    frames_dec = frames_left_r - 8'd1;
    bits_dec   = bits_left_r - BITS_W'(1);
  end

  always_comb begin
    phase_nxt       = phase_r;
    time_left_nxt   = time_left_r;
    frame_nxt       = frame_r;
    bits_left_nxt   = bits_left_r;
    frames_left_nxt = frames_left_r;
    if (item_go) begin
      if (item.op == OP_START) begin
        if (phase_r == PH_IDLE) begin
          frame_nxt       = new_frame;
          bits_left_nxt   = '0;
          frames_left_nxt = frame_cnt;
          if (frame_cnt != 8'd0) begin
            phase_nxt     = PH_HDR_MARK;
            time_left_nxt = t_unit8;
          end
        end
      end else if (phase_r != PH_IDLE) begin
        time_left_nxt = t_dec;
        if (t_dec == '0) begin
          unique case (phase_r)
            PH_HDR_MARK: begin
              phase_nxt     = PH_HDR_SPACE;
              time_left_nxt = t_unit4;
            end
            PH_HDR_SPACE: begin
              bits_left_nxt = BITS_W'(FRAME_BITS);
              phase_nxt     = PH_BIT_MARK;
              time_left_nxt = t_unit1;
            end
            PH_BIT_MARK: begin
              phase_nxt     = PH_BIT_SPACE;
              time_left_nxt = frame_r[0] ? t_unit3 : t_unit1;
            end
            PH_BIT_SPACE: begin
              frame_nxt     = {frame_r[0], frame_r[FRAME_BITS-1:1]};
              bits_left_nxt = bits_dec;
              phase_nxt     = (bits_dec != '0) ? PH_BIT_MARK : PH_STOP_MARK;
              time_left_nxt = t_unit1;
            end
            PH_STOP_MARK: begin
              frames_left_nxt = frames_dec;
              if (frames_dec == 8'd0) begin
                phase_nxt     = PH_IDLE;
                time_left_nxt = '0;
              end else if (cfg.repeat_gap_us == '0) begin
                phase_nxt     = PH_HDR_MARK;
                time_left_nxt = t_unit8;
              end else begin
                phase_nxt     = PH_GAP;
                time_left_nxt = t_gap;
              end
            end
            PH_GAP: begin
              phase_nxt     = PH_HDR_MARK;
              time_left_nxt = t_unit8;
            end
            default: begin
              phase_nxt     = PH_IDLE;
              time_left_nxt = '0;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    res = '0;
    if (item.op == OP_START) begin
      res.start_rejected = (phase_r != PH_IDLE);
      res.busy_res       = (phase_nxt != PH_IDLE);
    end else begin
      res.busy_res = (phase_r != PH_IDLE);
      res.ir_mark  = (phase_r == PH_HDR_MARK) || (phase_r == PH_BIT_MARK)
                     || (phase_r == PH_STOP_MARK);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      time_left_r   <= '0;
      frames_left_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      time_left_r   <= time_left_nxt;
      frames_left_r <= frames_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      bits_left_r <= '0;
    end else begin
      frame_r     <= frame_nxt;
      bits_left_r <= bits_left_nxt;
    end
  end

endmodule

@@ tb/tb_kaseikyo_ir_frame_transmitter.sv @@
module tb_kaseikyo_ir_frame_transmitter;
  import kir_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kaseikyo_ir_frame_transmitter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the sequencer, advanced once per accepted request.
  logic [UNIT_W-1:0] unit_cfg;
  logic [GAP_W-1:0] gap_cfg;
  frame_t shift_reg;
  bits_t bits_rem;
  phase_t ph;
  timer_t tmr;
  logic [7:0] frames_rem;

  res_t envelope_due[$];
  res_t want_res;
  bit quiet_mode = 1'b0;
  int stall_left = 0;
  int errors = 0;
  int total_requests = 0;
  int total_starts = 0;
  int total_rejects = 0;
  int total_marks = 0;
  int total_frames = 0;

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic timer_t unit_span(input int unsigned n);
    logic [31:0] u;
    logic [31:0] prod;
    u = (unit_cfg == '0) ? 32'd1 : 32'(unit_cfg);
    prod = u * n;
    if (prod > 32'(TIMER_MAX)) return TIMER_MAX;
    return prod[TIMER_BITS-1:0];
  endfunction

  function automatic void open_header();
    ph = PH_HDR_MARK;
    tmr = unit_span(8);
    total_frames++;
  endfunction

  function automatic void advance_phase();
    case (ph)
      PH_HDR_MARK: begin
        ph = PH_HDR_SPACE;
        tmr = unit_span(4);
      end
      PH_HDR_SPACE: begin
        bits_rem = bits_t'(FRAME_BITS);
        ph = PH_BIT_MARK;
        tmr = unit_span(1);
      end
      PH_BIT_MARK: begin
        ph = PH_BIT_SPACE;
        tmr = unit_span(shift_reg[0] ? 3 : 1);
      end
      PH_BIT_SPACE: begin
        shift_reg = {shift_reg[0], shift_reg[FRAME_BITS-1:1]};
        bits_rem = bits_rem - 1'b1;
        ph = (bits_rem != '0) ? PH_BIT_MARK : PH_STOP_MARK;
        tmr = unit_span(1);
      end
      PH_STOP_MARK: begin
        frames_rem = frames_rem - 8'd1;
        if (frames_rem == 8'd0) begin
          ph = PH_IDLE;
          tmr = '0;
        end else if (gap_cfg == '0) begin
          open_header();
        end else begin
          ph = PH_GAP;
          tmr = timer_t'(gap_cfg);
        end
      end
      PH_GAP: begin
        open_header();
      end
      default: begin
        ph = PH_IDLE;
        tmr = '0;
      end
    endcase
  endfunction

  function automatic res_t predict_envelope(input req_t item);
    res_t o;
    logic [15:0] ven;
    logic [3:0] vnib;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] par;
    o = '0;
    if (item.op == OP_START) begin
      if (ph != PH_IDLE) begin
        o.start_rejected = 1'b1;
      end else begin
        ven = item.vendor_code;
        vnib = ven[3:0] ^ ven[7:4] ^ ven[11:8] ^ ven[15:12];
        b2 = {item.address[3:0], vnib};
        b3 = item.address[11:4];
        par = b2 ^ b3 ^ item.command;
        shift_reg = {par, item.command, b3, b2, ven};
        bits_rem = '0;
        frames_rem = item.repeats + 8'd1;
        if (frames_rem != 8'd0) open_header();
      end
      o.busy_res = (ph != PH_IDLE);
    end else if (ph != PH_IDLE) begin
      o.busy_res = 1'b1;
      o.ir_mark = (ph == PH_HDR_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
      tmr = tmr - 1'b1;
      if (tmr == '0) advance_phase();
    end
    return o;
  endfunction

  function automatic req_t random_item(input logic op);
    req_t r;
    r.op = op;
    r.address = 12'($urandom_range(0, 4095));
    r.command = 8'($urandom_range(0, 255));
    r.vendor_code = 16'($urandom_range(0, 65535));
    r.repeats = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic req_t make_start(input logic [11:0] addr, input logic [7:0] cmd,
                                      input logic [15:0] ven, input logic [7:0] rep);
    req_t r;
    r.op = OP_START;
    r.address = addr;
    r.command = cmd;
    r.vendor_code = ven;
    r.repeats = rep;
    return r;
  endfunction

  task automatic send_request(input req_t item);
    int hold;
    res_t want;
    hold = 0;
    if (!quiet_mode && $urandom_range(0, 3) == 0) hold = idle_span();
    if (hold > 0) begin
      in_valid <= 1'b0;
      repeat (hold) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_envelope(item);
    envelope_due.push_back(want);
    total_requests++;
    if (item.op == OP_START) total_starts++;
    if (want.start_rejected) total_rejects++;
    if (want.ir_mark) total_marks++;
    @(negedge clk);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_request(random_item(OP_TICK));
  endtask

  task automatic tick_until_idle();
    while (ph != PH_IDLE) send_request(random_item(OP_TICK));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (envelope_due.size() != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_UNIT_US) begin
      unit_cfg = val[UNIT_W-1:0];
    end else begin
      gap_cfg = val[GAP_W-1:0];
    end
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet_mode && $urandom_range(0, 7) == 0) stall_left <= idle_span();
    end
  end

  task automatic report_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s expected %b, actual %b", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (envelope_due.size() == 0) begin
        $display("%0t: result expected none, actual %b", $time, out_data);
        errors++;
      end else begin
        want_res = envelope_due.pop_front();
        report_field("ir_mark", want_res.ir_mark, out_data.ir_mark);
        report_field("busy_res", want_res.busy_res, out_data.busy_res);
        report_field("start_rejected", want_res.start_rejected, out_data.start_rejected);
      end
    end
  end

  task automatic test_idle_behaviour();
    run_ticks(3);
    // A repeat count of 255 wraps the frame count to zero.
    send_request(make_start(12'hFFF, 8'hFF, 16'hFFFF, 8'd255));
    run_ticks(2);
  endtask

  task automatic test_reset_timing();
    quiet_mode = 1'b1;
    send_request(make_start(12'hFFF, 8'hFF, 16'hFFFF, 8'd255));
    run_ticks(5);
    send_request(make_start(12'h000, 8'h00, 16'h0000, 8'd255));
    run_ticks(2);
    quiet_mode = 1'b0;
  endtask

  task automatic test_field_extremes();
    write_reg(CFG_UNIT_US, 20'd1);
    write_reg(CFG_REPEAT_GAP_US, 20'd0);
    send_request(make_start(12'hFFF, 8'hFF, 16'hFFFF, 8'd1));
    run_ticks(20);
    send_request(make_start(12'h000, 8'h00, 16'h0000, 8'd0));
    tick_until_idle();
    send_request(make_start(12'hAAA, 8'h3C, 16'h5A5A, 8'd0));
    send_request(make_start(12'h555, 8'hC3, 16'hA5A5, 8'd0));
    tick_until_idle();
  endtask

  task automatic test_unit_extremes();
    quiet_mode = 1'b1;
    write_reg(CFG_UNIT_US, 20'd0);
    send_request(make_start(12'hC5A, 8'h96, 16'h0F0F, 8'd0));
    tick_until_idle();
    write_reg(CFG_UNIT_US, 20'd12);
    send_request(make_start(12'h123, 8'h81, 16'h8001, 8'd0));
    run_ticks(100);
    // Shorten the unit part-way through so the rest of the frame stays brief.
    write_reg(CFG_UNIT_US, 20'd1);
    tick_until_idle();
    quiet_mode = 1'b0;
  endtask

  task automatic test_repeat_gaps();
    write_reg(CFG_UNIT_US, 20'd2);
    write_reg(CFG_REPEAT_GAP_US, 20'd7);
    send_request(make_start(12'h0F0, 8'h5A, 16'h1234, 8'd1));
    tick_until_idle();
  endtask

  task automatic test_random_traffic();
    int first;
    int pick;
    logic [CFG_DATA_W-1:0] unit_val;
    logic [CFG_DATA_W-1:0] gap_val;
    req_t opener;
    first = total_requests;
    while (total_requests - first < 500) begin
      quiet_mode = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) unit_val = 20'd0;
        else if (pick < 7) unit_val = 20'd1;
        else if (pick < 9) unit_val = 20'd2;
        else unit_val = CFG_DATA_W'($urandom_range(3, 6));
        pick = $urandom_range(0, 9);
        if (pick < 2) gap_val = 20'd0;
        else if (pick < 9) gap_val = CFG_DATA_W'($urandom_range(1, 20));
        else gap_val = CFG_DATA_W'($urandom_range(100, 400));
        write_reg(CFG_UNIT_US, unit_val);
        write_reg(CFG_REPEAT_GAP_US, gap_val);
      end
      run_ticks($urandom_range(0, 2));
      opener = random_item(OP_START);
      pick = $urandom_range(0, 15);
      if (pick == 0) opener.repeats = 8'd255;
      else if (pick < 11) opener.repeats = 8'd0;
      else opener.repeats = 8'($urandom_range(1, 3));
      send_request(opener);
      while (ph != PH_IDLE) begin
        if ($urandom_range(0, 24) == 0) begin
          send_request(random_item(OP_START));
        end else begin
          send_request(random_item(OP_TICK));
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    int waited;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    unit_cfg = UNIT_RESET;
    gap_cfg = GAP_RESET;
    shift_reg = '0;
    bits_rem = '0;
    ph = PH_IDLE;
    tmr = '0;
    frames_rem = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_behaviour();
    test_reset_timing();
    test_field_extremes();
    test_unit_extremes();
    test_repeat_gaps();
    test_random_traffic();

    in_valid <= 1'b0;
    waited = 0;
    while (envelope_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (envelope_due.size() != 0) begin
      $display("%0t: %0d results still outstanding", $time, envelope_due.size());
      errors++;
    end
    $display("Sent %0d requests: %0d starts, %0d of them turned away while busy.",
             total_requests, total_starts, total_rejects);
    $display("Frames begun: %0d; envelope ticks with the carrier on: %0d.",
             total_frames, total_marks);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(64'd50_000_000);
    $display("Timed out waiting for the transmitter.");
    $display("Mismatches found");
    $finish;
  end

endmodule
